### hw/rtl/imht_pkg.sv
// ----------------------------------------------------------------------------
// imht_pkg
// Shared types, sizes and codes for the indexed min-heap timer queue.
// ----------------------------------------------------------------------------
package imht_pkg;

  localparam int HEAP_CAPACITY = 32;
  localparam int HIDX_W        = $clog2(HEAP_CAPACITY);
  localparam int CNT_W         = HIDX_W + 1;
  localparam int ID_W          = 10;
  localparam int ID_SPACE      = 1 << ID_W;
  localparam int TIME_BITS     = 48;
  localparam int TMO_W         = 31;
  localparam int REM_W         = 32;

  localparam logic [REM_W-1:0] REM_MAX = {1'b0, {(REM_W-1){1'b1}}};

  // commands
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_FIRE   = 3'd1;
  localparam logic [2:0] CMD_ADJUST = 3'd2;
  localparam logic [2:0] CMD_EXPIRE = 3'd3;
  localparam logic [2:0] CMD_POP    = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;
  localparam logic [2:0] CMD_NEXT   = 3'd6;

  // result kinds
  localparam logic [1:0] EV_FIRED  = 2'd0;
  localparam logic [1:0] EV_REPORT = 2'd1;
  localparam logic [1:0] EV_DONE   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [ID_W-1:0]      id;
  } heap_entry_t;

endpackage

### hw/rtl/imht_heap_mem.sv
// ----------------------------------------------------------------------------
// imht_heap_mem
// Heap slot storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module imht_heap_mem (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [imht_pkg::HIDX_W-1:0] rd_addr_a,
  input  logic [imht_pkg::HIDX_W-1:0] rd_addr_b,
  output imht_pkg::heap_entry_t       rd_data_a,
  output imht_pkg::heap_entry_t       rd_data_b,
  input  logic                        wr_en,
  input  logic [imht_pkg::HIDX_W-1:0] wr_addr,
  input  imht_pkg::heap_entry_t       wr_data
);

  imht_pkg::heap_entry_t mem [imht_pkg::HEAP_CAPACITY];
  imht_pkg::heap_entry_t rd_a_r;
  imht_pkg::heap_entry_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while no read is issued
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

### hw/rtl/indexed_min_heap_timer.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_timer
// Timer queue held as a binary min-heap of (id, deadline) with an id to
// slot map; add/update, fire, adjust, expire, pop, clear, next deadline.
// ----------------------------------------------------------------------------
//  channel | ports                                             | dir
//  in      | in_valid/in_ready, command, timer_id, timeout, now | in
//  out     | out_valid/out_ready, event_kind, fired_id,         | out
//          | remaining_ms, status, last                         |
//
// One command at a time. Lookup of an id reads the slot map, then the
// heap slot, then checks it; each heap level of a sift is one memory
// read, then one compare and write back; final placement and closing
// word follow, and every timer fired adds a removal and its sift. Heap
// slots are walked with a hole; the moving entry stays in a register.
// Reset clears the count and control only; memories keep contents, and an
// id counts as present only if its slot is live and holds that id.
// A stalled out_ready holds the engine at its next word.
// ----------------------------------------------------------------------------
module indexed_min_heap_timer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_command,
  input  logic [imht_pkg::ID_W-1:0]           in_timer_id,
  input  logic [imht_pkg::TMO_W-1:0]          in_timeout_ms,
  input  logic [imht_pkg::TIME_BITS-1:0]      in_now_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_event_kind,
  output logic [imht_pkg::ID_W-1:0]           out_fired_id,
  output logic signed [imht_pkg::REM_W-1:0]   out_remaining_ms,
  output logic [1:0]                          out_status,
  output logic                                out_last
);

  localparam int HW = imht_pkg::HIDX_W;
  localparam int CW = imht_pkg::CNT_W;
  localparam int TW = imht_pkg::TIME_BITS;
  localparam int RW = imht_pkg::REM_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LK_HEAP = 4'd1;
  localparam logic [3:0] S_LK_CHK  = 4'd2;
  localparam logic [3:0] S_FIRE    = 4'd3;
  localparam logic [3:0] S_RM_RD   = 4'd4;
  localparam logic [3:0] S_RM_LD   = 4'd5;
  localparam logic [3:0] S_SD_RD   = 4'd6;
  localparam logic [3:0] S_SD_CMP  = 4'd7;
  localparam logic [3:0] S_SU_RD   = 4'd8;
  localparam logic [3:0] S_SU_CMP  = 4'd9;
  localparam logic [3:0] S_PLACE   = 4'd10;
  localparam logic [3:0] S_EX_RD   = 4'd11;
  localparam logic [3:0] S_EX_CMP  = 4'd12;
  localparam logic [3:0] S_RPT     = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0]                   state_r, state_nxt;
  logic [2:0]                   cmd_r, cmd_nxt;
  logic [imht_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [TW-1:0]                now_r, now_nxt;
  logic [TW-1:0]                dl_r, dl_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [HW-1:0]                hole_r, hole_nxt;
  imht_pkg::heap_entry_t        cur_r, cur_nxt;
  logic                         moved_r, moved_nxt;
  logic                         exp_r, exp_nxt;
  logic [1:0]                   st_r, st_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic [imht_pkg::ID_W-1:0]    fid_r, fid_nxt;
  logic [RW-1:0]                rem_r, rem_nxt;
  logic [1:0]                   ost_r, ost_nxt;
  logic                         last_r, last_nxt;

  // id to slot map
  logic [HW-1:0]                pos_mem [imht_pkg::ID_SPACE];
  logic [HW-1:0]                pos_q_r;
  logic                         pos_re;
  logic                         pos_we;
  logic [imht_pkg::ID_W-1:0]    pos_wa;

  logic                         hm_rd_en;
  logic [HW-1:0]                hm_ra_a, hm_ra_b;
  imht_pkg::heap_entry_t        rd_a, rd_b;
  logic                         hm_we;
  imht_pkg::heap_entry_t        hm_wd;

  logic                         out_free;
  logic [TW:0]                  dl_sum;
  logic [CW-1:0]                c_idx;
  logic [CW:0]                  c_idx1;
  logic [HW-1:0]                par_idx;
  logic [CW-1:0]                n_cnt;
  logic                         known;
  logic                         pick_b;
  imht_pkg::heap_entry_t        best;
  logic [HW-1:0]                best_idx;
  logic [TW-1:0]                diff;

  imht_heap_mem u_heap (
    .clk       (clk),
    .rd_en     (hm_rd_en),
    .rd_addr_a (hm_ra_a),
    .rd_addr_b (hm_ra_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .wr_en     (hm_we),
    .wr_addr   (hole_r),
    .wr_data   (hm_wd)
  );

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= hole_r;
    end
    if (pos_re) begin
      pos_q_r <= pos_mem[in_timer_id];
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  assign dl_sum  = (TW+1)'(in_now_ms) + (TW+1)'(in_timeout_ms);
  assign c_idx   = {hole_r, 1'b1};
  assign c_idx1  = (CW+1)'(c_idx) + (CW+1)'(1);
  assign par_idx = (hole_r - HW'(1)) >> 1;
  assign n_cnt   = count_r - CW'(1);
  assign known   = ({1'b0, pos_q_r} < count_r) && (rd_a.id == id_r);
  assign pick_b  = (c_idx1 < (CW+1)'(count_r)) && (rd_b.deadline < rd_a.deadline);
  assign best    = pick_b ? rd_b : rd_a;
  assign best_idx = pick_b ? c_idx1[HW-1:0] : c_idx[HW-1:0];
  assign diff    = rd_a.deadline - now_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    now_nxt       = now_r;
    dl_nxt        = dl_r;
    count_nxt     = count_r;
    hole_nxt      = hole_r;
    cur_nxt       = cur_r;
    moved_nxt     = moved_r;
    exp_nxt       = exp_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    fid_nxt       = fid_r;
    rem_nxt       = rem_r;
    ost_nxt       = ost_r;
    last_nxt      = last_r;
    pos_re        = 1'b0;
    pos_we        = 1'b0;
    pos_wa        = cur_r.id;
    hm_rd_en      = 1'b0;
    hm_ra_a       = '0;
    hm_ra_b       = '0;
    hm_we         = 1'b0;
    hm_wd         = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          id_nxt    = in_timer_id;
          now_nxt   = in_now_ms;
          dl_nxt    = dl_sum[TW] ? {TW{1'b1}} : dl_sum[TW-1:0];
          exp_nxt   = 1'b0;
          moved_nxt = 1'b0;
          st_nxt    = imht_pkg::ST_OK;
          case (in_command) inside
            imht_pkg::CMD_ADD, imht_pkg::CMD_FIRE, imht_pkg::CMD_ADJUST: begin
              pos_re    = 1'b1;
              state_nxt = S_LK_HEAP;
            end
            imht_pkg::CMD_EXPIRE, imht_pkg::CMD_NEXT: begin
              exp_nxt   = 1'b1;
              state_nxt = S_EX_RD;
            end
            imht_pkg::CMD_POP: begin
              hole_nxt = '0;
              if (count_r == '0) begin
                st_nxt    = imht_pkg::ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RM_RD;
              end
            end
            imht_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_LK_HEAP: begin
        hm_rd_en  = 1'b1;
        hm_ra_a   = pos_q_r;
        state_nxt = S_LK_CHK;
      end

      S_LK_CHK: begin
        hole_nxt = pos_q_r;
        cur_nxt  = '{deadline: dl_r, id: id_r};
        if (known) begin
          state_nxt = (cmd_r == imht_pkg::CMD_FIRE) ? S_FIRE : S_SD_RD;
        end else if (cmd_r == imht_pkg::CMD_ADD) begin
          if (count_r >= CW'(imht_pkg::HEAP_CAPACITY)) begin
            st_nxt    = imht_pkg::ST_FULL;
            state_nxt = S_DONE;
          end else begin
            hole_nxt  = count_r[HW-1:0];
            count_nxt = count_r + CW'(1);
            state_nxt = S_SU_RD;
          end
        end else begin
          st_nxt    = imht_pkg::ST_UNKNOWN;
          state_nxt = S_DONE;
        end
      end

      S_FIRE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = imht_pkg::EV_FIRED;
          fid_nxt       = id_r;
          rem_nxt       = '0;
          ost_nxt       = imht_pkg::ST_OK;
          last_nxt      = 1'b0;
          state_nxt     = S_RM_RD;
        end
      end

      // remove the slot at the hole: last entry refills it
      S_RM_RD: begin
        count_nxt = n_cnt;
        moved_nxt = 1'b0;
        if ({1'b0, hole_r} < n_cnt) begin
          hm_rd_en  = 1'b1;
          hm_ra_a   = n_cnt[HW-1:0];
          state_nxt = S_RM_LD;
        end else begin
          state_nxt = exp_r ? S_EX_RD : S_DONE;
        end
      end

      S_RM_LD: begin
        cur_nxt   = rd_a;
        state_nxt = S_SD_RD;
      end

      S_SD_RD: begin
        if (c_idx < count_r) begin
          hm_rd_en  = 1'b1;
          hm_ra_a   = c_idx[HW-1:0];
          hm_ra_b   = c_idx1[HW-1:0];
          state_nxt = S_SD_CMP;
        end else begin
          state_nxt = moved_r ? S_PLACE : S_SU_RD;
        end
      end

      S_SD_CMP: begin
        if (cur_r.deadline < best.deadline) begin
          state_nxt = moved_r ? S_PLACE : S_SU_RD;
        end else begin
          hm_we     = 1'b1;
          hm_wd     = best;
          pos_we    = 1'b1;
          pos_wa    = best.id;
          hole_nxt  = best_idx;
          moved_nxt = 1'b1;
          state_nxt = S_SD_RD;
        end
      end

      S_SU_RD: begin
        if (hole_r == '0) begin
          state_nxt = S_PLACE;
        end else begin
          hm_rd_en  = 1'b1;
          hm_ra_a   = par_idx;
          state_nxt = S_SU_CMP;
        end
      end

      S_SU_CMP: begin
        if (rd_a.deadline < cur_r.deadline) begin
          state_nxt = S_PLACE;
        end else begin
          hm_we     = 1'b1;
          hm_wd     = rd_a;
          pos_we    = 1'b1;
          pos_wa    = rd_a.id;
          hole_nxt  = par_idx;
          state_nxt = S_SU_RD;
        end
      end

      S_PLACE: begin
        hm_we     = 1'b1;
        pos_we    = 1'b1;
        state_nxt = exp_r ? S_EX_RD : S_DONE;
      end

      S_EX_RD: begin
        if (count_r == '0) begin
          state_nxt = (cmd_r == imht_pkg::CMD_NEXT) ? S_RPT : S_DONE;
        end else begin
          hm_rd_en  = 1'b1;
          hm_ra_a   = '0;
          state_nxt = S_EX_CMP;
        end
      end

      S_EX_CMP: begin
        if (rd_a.deadline <= now_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = imht_pkg::EV_FIRED;
            fid_nxt       = rd_a.id;
            rem_nxt       = '0;
            ost_nxt       = imht_pkg::ST_OK;
            last_nxt      = 1'b0;
            hole_nxt      = '0;
            state_nxt     = S_RM_RD;
          end
        end else begin
          state_nxt = (cmd_r == imht_pkg::CMD_NEXT) ? S_RPT : S_DONE;
        end
      end

      // root word is still in rd_a when the heap is not empty
      S_RPT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = imht_pkg::EV_REPORT;
          fid_nxt       = '0;
          last_nxt      = 1'b1;
          if (count_r == '0) begin
            rem_nxt = '1;
            ost_nxt = imht_pkg::ST_EMPTY;
          end else begin
            ost_nxt = imht_pkg::ST_OK;
            if (rd_a.deadline <= now_r) begin
              rem_nxt = '0;
            end else if (diff > TW'(imht_pkg::REM_MAX)) begin
              rem_nxt = imht_pkg::REM_MAX;
            end else begin
              rem_nxt = diff[RW-1:0];
            end
          end
          state_nxt = S_IDLE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = imht_pkg::EV_DONE;
          fid_nxt       = '0;
          rem_nxt       = '0;
          ost_nxt       = st_r;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    id_r    <= id_nxt;
    now_r   <= now_nxt;
    dl_r    <= dl_nxt;
    hole_r  <= hole_nxt;
    cur_r   <= cur_nxt;
    moved_r <= moved_nxt;
    exp_r   <= exp_nxt;
    st_r    <= st_nxt;
    kind_r  <= kind_nxt;
    fid_r   <= fid_nxt;
    rem_r   <= rem_nxt;
    ost_r   <= ost_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = kind_r;
  assign out_fired_id     = fid_r;
  assign out_remaining_ms = rem_r;
  assign out_status       = ost_r;
  assign out_last         = last_r;

endmodule

### hw/rtl/imht_checker.sv
// ----------------------------------------------------------------------------
// imht_checker
// Port-level checks on the result words of the timer queue.
// ----------------------------------------------------------------------------
module imht_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_event_kind,
  input logic [imht_pkg::ID_W-1:0]         out_fired_id,
  input logic signed [imht_pkg::REM_W-1:0] out_remaining_ms,
  input logic [1:0]                        out_status,
  input logic                              out_last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fired_id)
      && $stable(out_event_kind) && $stable(out_remaining_ms))
    else $error("result word changed while stalled");

  // a fired word is never the last one of its command
  a_fire_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == imht_pkg::EV_FIRED |->
      !out_last && out_status == imht_pkg::ST_OK && out_remaining_ms == 0)
    else $error("bad fired word");

  // closing words always end the command
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != imht_pkg::EV_FIRED |-> out_last && out_fired_id == '0)
    else $error("closing word without last");

  // empty report carries -1, and only an empty report does
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == imht_pkg::EV_REPORT |->
      (out_status == imht_pkg::ST_EMPTY) == (out_remaining_ms == -1))
    else $error("report value and status disagree");

  // a new command is taken only after the engine is back to idle
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("two commands in back-to-back cycles");

endmodule

bind indexed_min_heap_timer imht_checker u_imht_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_event_kind   (out_event_kind),
  .out_fired_id     (out_fired_id),
  .out_remaining_ms (out_remaining_ms),
  .out_status       (out_status),
  .out_last         (out_last)
);
